### rtl/lpg_pkg.sv
// Shared types and constants for the landmark point grouping block.
package lpg_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 11;
	localparam int DIST_W         = 12;
	localparam int GSIZE_W        = 7;
	localparam int SQ_W           = 2 * COORD_W;
	localparam int D2_W           = SQ_W + 1;
	localparam int LIM_W          = 2 * DIST_W;
	localparam int CFG_ADDR_W     = 2;
	localparam int IN_TDATA_W     = 24;
	localparam int OUT_TDATA_W    = 48;

	localparam logic [COORD_W-1:0] BOX_START = 11'd2000;
	localparam logic [COORD_W-1:0] PAD       = 11'd10;
	localparam logic [COORD_W-1:0] FIELD_MAX = 11'd2047;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DIST  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIST  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_GROUP = 2'd2;

	// One result item.
	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] roi_x;
		logic [COORD_W-1:0] roi_y;
		logic [COORD_W-1:0] roi_width;
		logic [COORD_W-1:0] roi_height;
		logic               last_roi;
	} roi_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;
		logic seed_rd;
		logic seed_load;
		logic scan_issue;
		logic push;
		logic finish;
	} lpg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flag_s;
		logic flag_k;
		logic pipe_busy;
		logic group_big;
		logic out_free;
	} lpg_stat_t;

endpackage

### rtl/lpg_ctrl.sv
// Controller state machine: loading, seed search, scan and result sequencing.
module lpg_ctrl import lpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int IDX_W      = $clog2(MAX_POINTS),
	parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  lpg_stat_t        stat,
	output lpg_cmd_t         cmd,
	output logic [IDX_W-1:0] wr_addr,
	output logic [IDX_W-1:0] s_addr,
	output logic [IDX_W-1:0] k_addr
);

	typedef enum logic [5:0] {
		ST_LOAD = 6'b000001,
		ST_SEEK = 6'b000010,
		ST_SEED = 6'b000100,
		ST_SCAN = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] s_q, s_d;
	logic [CNT_W-1:0] k_q, k_d;

	assign wr_addr = count_q[IDX_W-1:0];
	assign s_addr  = s_q[IDX_W-1:0];
	assign k_addr  = k_q[IDX_W-1:0];

	// Next-state and command decode.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		s_d      = s_q;
		k_d      = k_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (count_q < CNT_W'(MAX_POINTS)) begin
						cmd.wr_en = 1'b1;
						count_d   = count_q + CNT_W'(1);
					end
					if (in_last) begin
						s_d     = '0;
						state_d = ST_SEEK;
					end
				end
			end
			ST_SEEK: begin
				if (s_q == count_q) begin
					state_d = ST_DONE;
				end else if (stat.flag_s) begin
					s_d = s_q + CNT_W'(1);
				end else begin
					cmd.seed_rd = 1'b1;
					state_d     = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed_load = 1'b1;
				k_d           = s_q + CNT_W'(1);
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				if (k_q != count_q) begin
					cmd.scan_issue = !stat.flag_k;
					k_d            = k_q + CNT_W'(1);
				end else if (!stat.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!stat.group_big) begin
					s_d     = s_q + CNT_W'(1);
					state_d = ST_SEEK;
				end else if (stat.out_free) begin
					cmd.push = 1'b1;
					s_d      = s_q + CNT_W'(1);
					state_d  = ST_SEEK;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					count_d    = '0;
					state_d    = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			s_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			s_q     <= s_d;
			k_q     <= k_d;
		end
	end

endmodule

### rtl/lpg_dp.sv
// Datapath: point store, claim flags, distance pipeline, bounding box and output.
module lpg_dp import lpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int IDX_W      = $clog2(MAX_POINTS),
	parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DIST_W-1:0]     cfg_data,
	input  logic [COORD_W-1:0]    in_x,
	input  logic [COORD_W-1:0]    in_y,
	input  lpg_cmd_t              cmd,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [IDX_W-1:0]      s_addr,
	input  logic [IDX_W-1:0]      k_addr,
	output lpg_stat_t             stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output roi_t                  out_roi
);

	localparam int GW = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

	logic [DIST_W-1:0]   min_dist_q, max_dist_q;
	logic [GSIZE_W-1:0]  min_group_q;
	logic [LIM_W-1:0]    lo2_q, hi2_q;

	logic [COORD_W-1:0]  x_mem [MAX_POINTS];
	logic [COORD_W-1:0]  y_mem [MAX_POINTS];
	logic [COORD_W-1:0]  rd_x_q, rd_y_q;
	logic [IDX_W-1:0]    rd_addr;
	logic [MAX_POINTS-1:0] claimed_q;

	logic [COORD_W-1:0]  seed_x_q, seed_y_q;
	logic                valid_s1, valid_s2;
	logic [IDX_W-1:0]    idx_s1, idx_s2;
	logic [COORD_W-1:0]  x_s2, y_s2;
	logic [SQ_W-1:0]     sqx_s2, sqy_s2;
	logic [COORD_W-1:0]  dx, dy;
	logic [D2_W-1:0]     d2;
	logic                hit;

	logic [COORD_W-1:0]  bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;
	logic [CNT_W-1:0]    members_q;
	roi_t                hold_q, new_roi;
	logic                hold_v_q;
	logic [COORD_W-1:0]  mx, my;
	logic [COORD_W:0]    wsum, hsum;

	// Configuration registers and squared limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q  <= '0;
			max_dist_q  <= DIST_W'(100);
			min_group_q <= GSIZE_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MIN_DIST:  min_dist_q  <= cfg_data;
				CFG_MAX_DIST:  max_dist_q  <= cfg_data;
				CFG_MIN_GROUP: min_group_q <= cfg_data[GSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lo2_q <= min_dist_q * min_dist_q;
		hi2_q <= max_dist_q * max_dist_q;
	end

	// Point store: one write port, one registered read port.
	assign rd_addr = cmd.seed_rd ? s_addr : k_addr;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			x_mem[wr_addr] <= in_x;
			y_mem[wr_addr] <= in_y;
		end
		if (cmd.seed_rd || cmd.scan_issue) begin
			rd_x_q <= x_mem[rd_addr];
			rd_y_q <= y_mem[rd_addr];
		end
	end

	// Distance pipeline: absolute differences and squares, then the window test.
	assign dx  = (rd_x_q > seed_x_q) ? rd_x_q - seed_x_q : seed_x_q - rd_x_q;
	assign dy  = (rd_y_q > seed_y_q) ? rd_y_q - seed_y_q : seed_y_q - rd_y_q;
	assign d2  = D2_W'(sqx_s2) + D2_W'(sqy_s2);
	assign hit = valid_s2 && (LIM_W'(d2) > lo2_q) && (LIM_W'(d2) < hi2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= k_addr;
		idx_s2 <= idx_s1;
		x_s2   <= rd_x_q;
		y_s2   <= rd_y_q;
		sqx_s2 <= dx * dx;
		sqy_s2 <= dy * dy;
	end

	// Claim flags: set by the seed and by members, cleared after each set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
		end else if (cmd.finish) begin
			claimed_q <= '0;
		end else begin
			if (cmd.seed_load) claimed_q[s_addr] <= 1'b1;
			if (hit) claimed_q[idx_s2] <= 1'b1;
		end
	end

	// Seed latch, member count and bounding box.
	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			seed_x_q  <= rd_x_q;
			seed_y_q  <= rd_y_q;
			members_q <= CNT_W'(1);
			bmin_x_q  <= (rd_x_q < BOX_START) ? rd_x_q : BOX_START;
			bmin_y_q  <= (rd_y_q < BOX_START) ? rd_y_q : BOX_START;
			bmax_x_q  <= rd_x_q;
			bmax_y_q  <= rd_y_q;
		end else if (hit) begin
			members_q <= members_q + CNT_W'(1);
			if (x_s2 < bmin_x_q) bmin_x_q <= x_s2;
			if (y_s2 < bmin_y_q) bmin_y_q <= y_s2;
			if (x_s2 > bmax_x_q) bmax_x_q <= x_s2;
			if (y_s2 > bmax_y_q) bmax_y_q <= y_s2;
		end
	end

	// Padded region of the finished group.
	always_comb begin
		mx   = (bmin_x_q >= PAD) ? bmin_x_q - PAD : bmin_x_q;
		my   = (bmin_y_q >= PAD) ? bmin_y_q - PAD : bmin_y_q;
		wsum = {1'b0, bmax_x_q} - {1'b0, mx} + {1'b0, PAD};
		hsum = {1'b0, bmax_y_q} - {1'b0, my} + {1'b0, PAD};
		new_roi            = '0;
		new_roi.found      = 1'b1;
		new_roi.roi_x      = mx;
		new_roi.roi_y      = my;
		new_roi.roi_width  = wsum[COORD_W] ? FIELD_MAX : wsum[COORD_W-1:0];
		new_roi.roi_height = hsum[COORD_W] ? FIELD_MAX : hsum[COORD_W-1:0];
	end

	// One region is held back until it is known whether it is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.push) begin
				hold_v_q  <= 1'b1;
				out_valid <= hold_v_q;
			end else if (cmd.finish) begin
				hold_v_q  <= 1'b0;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hold_q <= new_roi;
			if (hold_v_q) out_roi <= hold_q;
		end else if (cmd.finish) begin
			if (hold_v_q) begin
				out_roi          <= hold_q;
				out_roi.last_roi <= 1'b1;
			end else begin
				out_roi          <= '0;
				out_roi.last_roi <= 1'b1;
			end
		end
	end

	// Status back to the controller.
	assign stat.flag_s    = claimed_q[s_addr];
	assign stat.flag_k    = claimed_q[k_addr];
	assign stat.pipe_busy = valid_s1 || valid_s2;
	assign stat.group_big = GW'(members_q) > GW'(min_group_q);
	assign stat.out_free  = !out_valid || out_ready;

endmodule

### rtl/landmark_point_grouping_roi_core.sv
// Top level of the landmark point grouping block.
//
// Points stream in on the s_ channel, one transfer per cycle while loading.
// The transfer with s_tlast set closes the set and starts grouping; input
// is held off (s_tready low) until the set's results have been issued.
// Each region leaves on the m_ channel as one transfer; m_tuser is the
// found flag and m_tlast marks the final result of the set. A set with
// no region gives a single transfer with m_tuser low and m_tlast high.
// Grouping for a stored set: each unclaimed seed is read in ST_SEEK and
// latched in ST_SEED, then the later points are scanned, one per cycle,
// the distance pipeline drains and the group is emitted; a claimed seed
// is skipped. The single read port of the point store serialises the
// scan. One region is held back internally so that the last one can be
// flagged; a stalled m_ channel stops grouping at the next emit.
// Reset clears the set, the claim flags, the output and restores the
// configuration defaults (min 0, max 100, group size 3).
module landmark_point_grouping_roi_core import lpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [DIST_W-1:0]      cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // point_x, point_y
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // roi_x, roi_y, roi_width, roi_height
	output logic                   m_tuser,   // found
	output logic                   m_tlast
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	lpg_cmd_t         cmd;
	lpg_stat_t        stat;
	logic [IDX_W-1:0] wr_addr, s_addr, k_addr;
	roi_t             out_roi;

	lpg_ctrl #(
		.MAX_POINTS(MAX_POINTS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_last(s_tlast),
		.in_ready(s_tready),
		.stat(stat),
		.cmd(cmd),
		.wr_addr(wr_addr),
		.s_addr(s_addr),
		.k_addr(k_addr)
	);

	lpg_dp #(
		.MAX_POINTS(MAX_POINTS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_x(s_tdata[COORD_W-1:0]),
		.in_y(s_tdata[2*COORD_W-1:COORD_W]),
		.cmd(cmd),
		.wr_addr(wr_addr),
		.s_addr(s_addr),
		.k_addr(k_addr),
		.stat(stat),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_roi(out_roi)
	);

	// Output packing.
	assign m_tdata = {4'b0, out_roi.roi_height, out_roi.roi_width,
		out_roi.roi_y, out_roi.roi_x};
	assign m_tuser = out_roi.found;
	assign m_tlast = out_roi.last_roi;

	// A result without a region always closes its set.
	a_nofound_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without region not marked last");

	// Input is only taken while the scan pipeline is empty.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pipe_busy)
		else $error("input accepted while scan in flight");

	// Results are only written into a free output register.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push || cmd.finish |-> !m_tvalid || m_tready)
		else $error("output overwritten while stalled");

	// Scanning and seed loading never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed_load |-> !cmd.scan_issue && !stat.pipe_busy)
		else $error("seed loaded during scan");

endmodule

### tb/lpg_checker.sv
// Checker for the landmark point grouping block: predicts regions and compares transfers.
`timescale 1ns / 1ps

module lpg_checker import lpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [DIST_W-1:0]      cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tuser,
	input  logic                   m_tlast,
	output int                     fail_count,
	output int                     pending
);

	logic [COORD_W-1:0] xs [MAX_POINTS_DEF];
	logic [COORD_W-1:0] ys [MAX_POINTS_DEF];
	int                 npts;
	logic [DIST_W-1:0]  min_dist;
	logic [DIST_W-1:0]  max_dist;
	logic [GSIZE_W-1:0] min_group;
	roi_t               expected_rois [$];

	assign pending = expected_rois.size();

	// Clamp an extent to the field maximum.
	function automatic logic [COORD_W-1:0] clamp_extent(int v);
		return (v > 2047) ? FIELD_MAX : COORD_W'(v);
	endfunction

	// Append one predicted region at the tail of the queue.
	task automatic add_expected(input roi_t r);
		expected_rois.insert(expected_rois.size(), r);
	endtask

	// Group the stored set and queue the regions it yields.
	task automatic group_set();
		bit   claimed [MAX_POINTS_DEF];
		int   lo2;
		int   hi2;
		int   members;
		int   bx0;
		int   by0;
		int   bx1;
		int   by1;
		int   dx;
		int   dy;
		int   d2;
		int   n;
		roi_t r;
		lo2 = int'(min_dist) * int'(min_dist);
		hi2 = int'(max_dist) * int'(max_dist);
		n = 0;
		foreach (claimed[i]) claimed[i] = 0;
		for (int s = 0; s < npts; s++) begin
			if (claimed[s]) continue;
			claimed[s] = 1;
			members = 1;
			bx0 = (xs[s] < 2000) ? xs[s] : 2000;
			by0 = (ys[s] < 2000) ? ys[s] : 2000;
			bx1 = xs[s];
			by1 = ys[s];
			for (int k = s + 1; k < npts; k++) begin
				if (claimed[k]) continue;
				dx = int'(xs[k]) - int'(xs[s]);
				dy = int'(ys[k]) - int'(ys[s]);
				d2 = dx * dx + dy * dy;
				if (d2 > lo2 && d2 < hi2) begin
					claimed[k] = 1;
					members++;
					if (xs[k] < bx0) bx0 = xs[k];
					if (ys[k] < by0) by0 = ys[k];
					if (xs[k] > bx1) bx1 = xs[k];
					if (ys[k] > by1) by1 = ys[k];
				end
			end
			if (members > int'(min_group)) begin
				if (bx0 >= 10) bx0 -= 10;
				if (by0 >= 10) by0 -= 10;
				r.found      = 1'b1;
				r.roi_x      = COORD_W'(bx0);
				r.roi_y      = COORD_W'(by0);
				r.roi_width  = clamp_extent(bx1 - bx0 + 10);
				r.roi_height = clamp_extent(by1 - by0 + 10);
				r.last_roi   = 1'b0;
				add_expected(r);
				n++;
			end
		end
		if (n == 0) begin
			r = '0;
			r.last_roi = 1'b1;
			add_expected(r);
		end else begin
			expected_rois[expected_rois.size() - 1].last_roi = 1'b1;
		end
		npts = 0;
	endtask

	// Track configuration, load points, and compare each output transfer.
	always @(posedge clk or negedge arst_n) begin
		roi_t got;
		roi_t exp_roi;
		if (!arst_n) begin
			npts       = 0;
			min_dist   <= 12'd0;
			max_dist   <= 12'd100;
			min_group  <= 7'd3;
			fail_count <= 0;
			expected_rois.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_MIN_DIST:  min_dist  <= cfg_data;
					CFG_MAX_DIST:  max_dist  <= cfg_data;
					CFG_MIN_GROUP: min_group <= cfg_data[GSIZE_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.found      = m_tuser;
				got.roi_x      = m_tdata[10:0];
				got.roi_y      = m_tdata[21:11];
				got.roi_width  = m_tdata[32:22];
				got.roi_height = m_tdata[43:33];
				got.last_roi   = m_tlast;
				if (expected_rois.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected region transfer: %p", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_roi = expected_rois.pop_front();
					if (got !== exp_roi) begin
						if (fail_count < 10)
							$display("Region mismatch: expected %p, actual %p", exp_roi, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (npts < MAX_POINTS_DEF) begin
					xs[npts] = s_tdata[10:0];
					ys[npts] = s_tdata[21:11];
					npts = npts + 1;
				end
				if (s_tlast) group_set();
			end
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top: stimulus, configuration phases and verdict for the grouping block.
`timescale 1ns / 1ps

module tb_top;
	import lpg_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [DIST_W-1:0]      cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	int                     fail_count;
	int                     pending;
	bit                     steady = 1'b0;

	always #1 clk = ~clk;

	landmark_point_grouping_roi_core u_top (.*);

	lpg_checker u_chk (.*);

	// Sink side: random stalls except during the steady stretch.
	always @(posedge clk)
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 28);

	// One register write; the write port is then left quiet before the task returns.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= DIST_W'(val);
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	// Send one point; hold until the transfer completes.
	task automatic send_point(input int px, input int py, input bit last);
		while (!steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, 11'(py), 11'(px)};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Release the input and wait until every expected result has come.
	task automatic drain_set();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// A cluster of points around a centre with a random spread.
	task automatic send_cluster(input int n, input int cx, input int cy, input int spread,
		input bit last);
		for (int i = 0; i < n; i++)
			send_point(cx + $urandom_range(spread), cy + $urandom_range(spread),
				last && (i == n - 1));
	endtask

	initial begin
		int nsets;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, extremes of the coordinates, lone last point.
		send_point(0, 0, 1'b1);
		drain_set();
		send_point(2047, 2047, 1'b0);
		send_point(2040, 2030, 1'b0);
		send_point(2045, 2047, 1'b0);
		send_point(2046, 2001, 1'b1);
		drain_set();
		send_point(5, 3, 1'b0);
		send_point(1, 9, 1'b0);
		send_point(12, 0, 1'b0);
		send_point(0, 7, 1'b0);
		send_point(1999, 1999, 1'b1);
		drain_set();

		// Extremes of configuration: wide window, big extents, zero group size.
		write_reg(CFG_MIN_DIST, 0);
		write_reg(CFG_MAX_DIST, 4095);
		write_reg(CFG_MIN_GROUP, 0);
		send_point(0, 0, 1'b0);
		send_point(2047, 2047, 1'b0);
		send_point(1000, 3, 1'b1);
		drain_set();
		write_reg(CFG_MIN_GROUP, 64);
		write_reg(CFG_MAX_DIST, 0);
		send_point(100, 100, 1'b1);
		drain_set();

		// Store overflow: 70 points, the dropped last still triggers grouping.
		write_reg(CFG_MIN_DIST, 4095);
		write_reg(CFG_MAX_DIST, 4095);
		write_reg(CFG_MIN_GROUP, 0);
		send_cluster(70, 0, 0, 2047, 1'b1);
		drain_set();

		// Random sets with varying settings; sender pauses for results each set.
		steady = 1'b1;
		nsets = 0;
		while (nsets < 6) begin
			if (nsets == 3) steady = 1'b0;
			write_reg(CFG_MIN_DIST, $urandom_range(8));
			write_reg(CFG_MAX_DIST, $urandom_range(20, 300));
			write_reg(CFG_MIN_GROUP, $urandom_range(4));
			repeat ($urandom_range(1, 4))
				send_cluster($urandom_range(1, 6), $urandom_range(2047), $urandom_range(2047),
					$urandom_range(1, 60), 1'b0);
			if ($urandom_range(3) == 0)
				send_point($urandom_range(2047), $urandom_range(2047), 1'b1);
			else
				send_cluster(2, $urandom_range(2047), $urandom_range(2047), 20, 1'b1);
			drain_set();
			nsets++;
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
